// File: rtl/rrsp_pkg.sv
// Shared types, character codes and event codes of the reply stream parser.
package rrsp_pkg;

    // One request on the input side: a reply byte or an end-of-buffer mark.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_data;
    } in_item_t;

    // One request on the output side.
    typedef struct packed {
        logic [1:0]  event_res;
        logic [7:0]  out_byte;
        logic [2:0]  reply_type;
        logic [15:0] element_index;
        logic        is_null;
        logic [2:0]  error_code;
        logic        last_of_item;
    } out_item_t;

    // Everything one input byte produces: one or two results.
    typedef struct packed {
        logic      two;
        out_item_t first;
        out_item_t second;
    } bundle_t;

    // Queue between parser and output side; the depth is a power of two.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] EV_PAYLOAD   = 2'd0;
    localparam logic [1:0] EV_ELEM_END  = 2'd1;
    localparam logic [1:0] EV_REPLY_END = 2'd2;
    localparam logic [1:0] EV_BAD       = 2'd3;

    localparam logic [2:0] TYPE_NONE   = 3'd0;
    localparam logic [2:0] TYPE_STATUS = 3'd1;
    localparam logic [2:0] TYPE_ERROR  = 3'd2;
    localparam logic [2:0] TYPE_INT    = 3'd3;
    localparam logic [2:0] TYPE_BULK   = 3'd4;
    localparam logic [2:0] TYPE_MULTI  = 3'd5;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_EMPTY    = 3'd1;
    localparam logic [2:0] ERR_BAD_TYPE = 3'd7;

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

endpackage

// File: rtl/rrsp_front.sv
// Parser front end: one byte per cycle unless queue_full; builds its results.
module rrsp_front #(
    parameter int LEN_BITS   = 32,
    parameter int COUNT_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  rrsp_pkg::in_item_t item,
    output logic               item_stall,
    input  logic               queue_full,
    output logic               push,
    output rrsp_pkg::bundle_t  push_data
);
    import rrsp_pkg::*;

    localparam int ACC_W  = (LEN_BITS > COUNT_BITS) ? LEN_BITS : COUNT_BITS;
    localparam int PROD_W = ACC_W + 4;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_LINE,
        PH_BLEN_FIRST,
        PH_BLEN,
        PH_BLEN_LF,
        PH_NULL_DIG,
        PH_NULL_LF,
        PH_BDATA,
        PH_BDATA_CR,
        PH_BDATA_LF,
        PH_CNT,
        PH_CNT_LF,
        PH_ELEM,
        PH_DRAIN
    } phase_t;

    phase_t                  phase_reg, phase_next;
    logic [2:0]              current_type_reg, current_type_next;
    logic                    pending_cr_reg, pending_cr_next;
    logic                    in_array_reg, in_array_next;
    logic [ACC_W-1:0]        acc_reg, acc_next;
    logic [COUNT_BITS-1:0]   elements_left_reg, elements_left_next;
    logic [COUNT_BITS-1:0]   element_number_reg, element_number_next;
    logic                    byte_seen_reg, byte_seen_next;

    logic                    take;
    logic [7:0]              b;
    logic                    is_digit;
    logic [3:0]              dig;
    logic [PROD_W-1:0]       prod;
    logic                    len_ovf;
    logic                    cnt_ovf;
    logic [2:0]              code;
    logic [COUNT_BITS+15:0]  elem_ext;
    logic [15:0]             elem_idx;
    logic [15:0]             pay_idx;

    logic [1:0]              pay_num;
    logic [7:0]              pay_b0;
    logic [7:0]              pay_b1;
    logic                    do_fail;
    logic [2:0]              fail_code;
    logic                    do_finish;
    logic                    fin_nul;
    logic                    do_cnt_end;
    logic                    any;
    out_item_t               r0, r1;
    logic                    two;

    assign take       = item_valid && !queue_full;
    assign item_stall = queue_full;

    assign b        = item.data_byte;
    assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    assign dig      = b[3:0];
    // Ten times the accumulator plus the new digit, with room to spot overflow.
    assign prod     = PROD_W'({acc_reg, 3'b000}) + PROD_W'({acc_reg, 1'b0}) + PROD_W'(dig);
    assign len_ovf  = |prod[PROD_W-1:LEN_BITS];
    assign cnt_ovf  = |prod[PROD_W-1:COUNT_BITS];
    assign code     = current_type_reg + 3'd1;
    assign elem_ext = {16'd0, element_number_reg};
    assign elem_idx = elem_ext[15:0];
    assign pay_idx  = in_array_reg ? elem_idx : 16'd0;

    always_comb
    begin
        phase_next          = phase_reg;
        current_type_next   = current_type_reg;
        pending_cr_next     = pending_cr_reg;
        in_array_next       = in_array_reg;
        acc_next            = acc_reg;
        elements_left_next  = elements_left_reg;
        element_number_next = element_number_reg;
        byte_seen_next      = byte_seen_reg;
        pay_num             = 2'd0;
        pay_b0              = b;
        pay_b1              = b;
        do_fail             = 1'b0;
        fail_code           = code;
        do_finish           = 1'b0;
        fin_nul             = 1'b0;
        do_cnt_end          = 1'b0;

        if (item.end_of_data)
        begin
            if (phase_reg == PH_IDLE)
            begin
                if (!byte_seen_reg)
                begin
                    do_fail   = 1'b1;
                    fail_code = ERR_EMPTY;
                end
            end
            else if (phase_reg != PH_DRAIN)
            begin
                do_fail = 1'b1;
            end
            phase_next      = PH_IDLE;
            in_array_next   = 1'b0;
            pending_cr_next = 1'b0;
            byte_seen_next  = 1'b0;
        end
        else
        begin
            byte_seen_next = 1'b1;
            unique case (phase_reg)
                PH_LINE:
                begin
                    if (pending_cr_reg)
                    begin
                        if (b == CH_LF)
                        begin
                            pending_cr_next = 1'b0;
                            do_finish       = 1'b1;
                        end
                        else if (b == CH_CR)
                        begin
                            pay_num = 2'd1;
                            pay_b0  = CH_CR;
                        end
                        else
                        begin
                            pay_num         = 2'd2;
                            pay_b0          = CH_CR;
                            pending_cr_next = 1'b0;
                        end
                    end
                    else if (b == CH_CR)
                    begin
                        pending_cr_next = 1'b1;
                    end
                    else
                    begin
                        pay_num = 2'd1;
                    end
                end
                PH_BLEN_FIRST, PH_BLEN:
                begin
                    if (phase_reg == PH_BLEN_FIRST && b == CH_MINUS)
                    begin
                        phase_next = PH_NULL_DIG;
                    end
                    else if (is_digit)
                    begin
                        phase_next = PH_BLEN;
                        if (len_ovf)
                        begin
                            do_fail = 1'b1;
                        end
                        else
                        begin
                            acc_next = prod[ACC_W-1:0];
                        end
                    end
                    else if (b == CH_CR)
                    begin
                        phase_next = PH_BLEN_LF;
                    end
                    else
                    begin
                        do_fail = 1'b1;
                    end
                end
                PH_BLEN_LF:
                begin
                    if (b == CH_LF)
                    begin
                        phase_next = (acc_reg == '0) ? PH_BDATA_CR : PH_BDATA;
                    end
                    else
                    begin
                        do_fail = 1'b1;
                    end
                end
                PH_BDATA:
                begin
                    pay_num  = 2'd1;
                    acc_next = acc_reg - ACC_W'(1);
                    if (acc_reg == ACC_W'(1))
                    begin
                        phase_next = PH_BDATA_CR;
                    end
                end
                PH_BDATA_CR:
                begin
                    if (b == CH_CR)
                    begin
                        phase_next = PH_BDATA_LF;
                    end
                    else
                    begin
                        do_fail = 1'b1;
                    end
                end
                PH_BDATA_LF:
                begin
                    if (b == CH_LF)
                    begin
                        do_finish = 1'b1;
                    end
                    else
                    begin
                        do_fail = 1'b1;
                    end
                end
                PH_NULL_DIG:
                begin
                    if (b == CH_CR)
                    begin
                        phase_next = PH_NULL_LF;
                    end
                    else if (!is_digit)
                    begin
                        do_fail = 1'b1;
                    end
                end
                PH_NULL_LF:
                begin
                    if (b == CH_LF)
                    begin
                        do_finish = 1'b1;
                        fin_nul   = 1'b1;
                    end
                    else
                    begin
                        do_fail = 1'b1;
                    end
                end
                PH_CNT:
                begin
                    if (is_digit)
                    begin
                        if (cnt_ovf)
                        begin
                            do_fail = 1'b1;
                        end
                        else
                        begin
                            acc_next = prod[ACC_W-1:0];
                        end
                    end
                    else if (b == CH_CR)
                    begin
                        phase_next = PH_CNT_LF;
                    end
                    else
                    begin
                        do_fail = 1'b1;
                    end
                end
                PH_CNT_LF:
                begin
                    if (b != CH_LF)
                    begin
                        do_fail = 1'b1;
                    end
                    else if (acc_reg == '0)
                    begin
                        do_cnt_end = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        elements_left_next  = acc_reg[COUNT_BITS-1:0];
                        element_number_next = COUNT_BITS'(1);
                        in_array_next       = 1'b1;
                        phase_next          = PH_ELEM;
                    end
                end
                PH_ELEM:
                begin
                    if (b == CH_PLUS || b == CH_MINUS || b == CH_COLON)
                    begin
                        pending_cr_next = 1'b0;
                        phase_next      = PH_LINE;
                    end
                    else if (b == CH_DOLLAR)
                    begin
                        acc_next   = '0;
                        phase_next = PH_BLEN_FIRST;
                    end
                    else
                    begin
                        do_fail = 1'b1;
                    end
                end
                PH_DRAIN:
                begin
                    phase_next = PH_DRAIN;
                end
                default:
                begin
                    // Idle: the byte names the reply type.
                    pending_cr_next = 1'b0;
                    in_array_next   = 1'b0;
                    acc_next        = '0;
                    if (b == CH_PLUS || b == CH_MINUS || b == CH_COLON)
                    begin
                        current_type_next = (b == CH_PLUS)  ? TYPE_STATUS :
                                            (b == CH_MINUS) ? TYPE_ERROR : TYPE_INT;
                        phase_next        = PH_LINE;
                    end
                    else if (b == CH_DOLLAR)
                    begin
                        current_type_next = TYPE_BULK;
                        phase_next        = PH_BLEN_FIRST;
                    end
                    else if (b == CH_STAR)
                    begin
                        current_type_next = TYPE_MULTI;
                        phase_next        = PH_CNT;
                    end
                    else
                    begin
                        current_type_next = TYPE_NONE;
                        do_fail           = 1'b1;
                        fail_code         = ERR_BAD_TYPE;
                    end
                end
            endcase

            if (do_fail)
            begin
                phase_next      = PH_DRAIN;
                in_array_next   = 1'b0;
                pending_cr_next = 1'b0;
            end
            else if (do_finish)
            begin
                if (in_array_reg)
                begin
                    elements_left_next = elements_left_reg - COUNT_BITS'(1);
                    if (elements_left_reg == COUNT_BITS'(1))
                    begin
                        in_array_next = 1'b0;
                        phase_next    = PH_IDLE;
                    end
                    else
                    begin
                        element_number_next = element_number_reg + COUNT_BITS'(1);
                        phase_next          = PH_ELEM;
                    end
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
        end
    end

    // Assemble the results of this byte in the order they leave the block.
    always_comb
    begin
        r0  = '0;
        r1  = '0;
        two = 1'b0;
        any = 1'b1;
        if (do_fail)
        begin
            r0.event_res  = EV_BAD;
            r0.error_code = fail_code;
        end
        else if (do_finish)
        begin
            if (in_array_reg)
            begin
                r0.event_res     = EV_ELEM_END;
                r0.reply_type    = current_type_reg;
                r0.element_index = elem_idx;
                r0.is_null       = fin_nul;
                if (elements_left_reg == COUNT_BITS'(1))
                begin
                    r1.event_res  = EV_REPLY_END;
                    r1.reply_type = current_type_reg;
                    two           = 1'b1;
                end
            end
            else
            begin
                r0.event_res  = EV_REPLY_END;
                r0.reply_type = current_type_reg;
                r0.is_null    = fin_nul;
            end
        end
        else if (do_cnt_end)
        begin
            r0.event_res  = EV_REPLY_END;
            r0.reply_type = current_type_reg;
        end
        else if (pay_num != 2'd0)
        begin
            r0.event_res     = EV_PAYLOAD;
            r0.out_byte      = pay_b0;
            r0.reply_type    = current_type_reg;
            r0.element_index = pay_idx;
            if (pay_num == 2'd2)
            begin
                r1.event_res     = EV_PAYLOAD;
                r1.out_byte      = pay_b1;
                r1.reply_type    = current_type_reg;
                r1.element_index = pay_idx;
                two              = 1'b1;
            end
        end
        else
        begin
            any = 1'b0;
        end
        if (two)
        begin
            r1.last_of_item = 1'b1;
        end
        else
        begin
            r0.last_of_item = 1'b1;
        end
    end

    assign push             = take && any;
    assign push_data.two    = two;
    assign push_data.first  = r0;
    assign push_data.second = r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            current_type_reg   <= TYPE_NONE;
            pending_cr_reg     <= 1'b0;
            in_array_reg       <= 1'b0;
            acc_reg            <= '0;
            elements_left_reg  <= '0;
            element_number_reg <= '0;
            byte_seen_reg      <= 1'b0;
        end
        else if (take)
        begin
            phase_reg          <= phase_next;
            current_type_reg   <= current_type_next;
            pending_cr_reg     <= pending_cr_next;
            in_array_reg       <= in_array_next;
            acc_reg            <= acc_next;
            elements_left_reg  <= elements_left_next;
            element_number_reg <= element_number_next;
            byte_seen_reg      <= byte_seen_next;
        end
    end

endmodule

// File: rtl/rrsp_queue.sv
// Short queue of result groups between the parser and the output stage.
module rrsp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rrsp_pkg::bundle_t push_data,
    output logic              full,
    input  logic              pop,
    output rrsp_pkg::bundle_t pop_data,
    output logic              empty
);
    import rrsp_pkg::*;

    bundle_t           mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

// File: rtl/rrsp_back.sv
// Output stage: from an output register, one queued result per unstalled cycle.
module rrsp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                empty,
    input  rrsp_pkg::bundle_t   head,
    output logic                pop,
    output logic                result_valid,
    input  logic                result_stall,
    output rrsp_pkg::out_item_t result
);
    import rrsp_pkg::*;

    out_item_t result_reg;
    logic      result_valid_reg;
    logic      half_reg;
    logic      load;

    assign load = !result_valid_reg || !result_stall;
    // A group of two leaves the queue only once its second result is sent.
    assign pop  = load && !empty && (!head.two || half_reg);

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            half_reg         <= 1'b0;
            result_reg       <= '0;
        end
        else if (load)
        begin
            result_valid_reg <= !empty;
            if (!empty)
            begin
                if (head.two && !half_reg)
                begin
                    result_reg <= head.first;
                    half_reg   <= 1'b1;
                end
                else if (head.two)
                begin
                    result_reg <= head.second;
                    half_reg   <= 1'b0;
                end
                else
                begin
                    result_reg <= head.first;
                end
            end
        end
    end

endmodule

// File: rtl/resp_reply_stream_parser.sv
// Top level of the streaming reply parser: parser, result queue and output stage.
//
// The block takes one reply byte, or an end-of-buffer mark, per request on the
// item channel and can accept a new request in every cycle with item_stall low.
// The parser front end classifies each byte in the cycle it arrives, updating its
// phase, length or count accumulator (one multiply by ten and add per digit) and
// element counters, and writes the zero, one or two results that byte causes
// as one group into a four-entry queue. The output stage drains that queue
// through a registered result port, one result per cycle while result_stall is
// low, so a byte that causes two results (a held-back CR followed by an
// ordinary byte, or the end of the final element followed by the end of its
// multi-bulk reply) sends them one after the other. Each result passes through
// the queue and then the output register. The item channel raises stall only
// when the queue holds four groups, which happens only while the result channel
// is stalled or two-result bytes pile up. There is no clearing pass after reset.
// LEN_BITS sets the largest bulk length and COUNT_BITS the largest element count
// that is accepted before the reply is flagged as bad.
module resp_reply_stream_parser #(
    parameter int LEN_BITS   = 32,
    parameter int COUNT_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  rrsp_pkg::in_item_t  item,
    output logic                result_valid,
    input  logic                result_stall,
    output rrsp_pkg::out_item_t result
);
    import rrsp_pkg::*;

    logic    push;
    bundle_t push_data;
    logic    queue_full;
    logic    queue_empty;
    logic    pop;
    bundle_t head;

    // Front end: parses one byte per accepted request and groups its results.
    rrsp_front #(
        .LEN_BITS   (LEN_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_stall (item_stall),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    // The queue lets the parser keep going while the result side is stalled.
    rrsp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (head),
        .empty     (queue_empty)
    );

    // Back end: splits each group into single results on the registered port.
    rrsp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (queue_empty),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
